[hw/rtl/preemptive_priority_scheduler_macros.svh]
// Assertion macros for the scheduler checker.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is high
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

[hw/rtl/pps_pkg.sv]
package pps_pkg;

   // Process store depth
   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   // Field widths
   localparam int ARR_W   = 16;
   localparam int BURST_W = 8;
   localparam int PRIO_W  = 8;
   localparam int PIDX_W  = 4;
   localparam int TIME_W  = 17;
   localparam int TAT_W   = 12;

   localparam logic [TAT_W-1:0] TAT_MAX = '1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic sim_start;
      logic scan;
      logic apply;
      logic fill;
      logic finish;
   } pps_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic start_run;
      logic empty_start;
      logic scan_last;
      logic run_done;
      logic out_last;
   } pps_status_type;

endpackage

[hw/rtl/pps_ifs.sv]
// Request channel: one process record per request
interface pps_req_if import pps_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ARR_W-1:0]     arrival_time;
   logic [BURST_W-1:0]   burst_time;
   logic [PRIO_W-1:0]    prio_level;
   logic                 last_process;

   modport source (output valid, arrival_time, burst_time, prio_level, last_process,
                   input ready);
   modport sink   (input valid, arrival_time, burst_time, prio_level, last_process,
                   output ready);
endinterface

// Response channel: one result per process
interface pps_rsp_if import pps_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [PIDX_W-1:0]    process_index;
   logic [TIME_W-1:0]    finish_time;
   logic [TAT_W-1:0]     turnaround_time;
   logic [TAT_W-1:0]     waiting_time;
   logic                 last_result;

   modport source (output valid, process_index, finish_time, turnaround_time,
                   waiting_time, last_result, input ready);
   modport sink   (input valid, process_index, finish_time, turnaround_time,
                   waiting_time, last_result, output ready);
endinterface

[hw/rtl/pps_ctrl.sv]
module pps_ctrl import pps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pps_status_type status,
   output pps_cmd_type    cmd
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_APPLY = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_HOLD  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_HOLD);

   // Sequence load, tick scans, result drain
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.start_run && !status.empty_start) begin
                  cmd.sim_start = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.run_done ? ST_FILL : ST_SCAN;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               if (status.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/pps_datapath.sv]
module pps_datapath import pps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pps_cmd_type        cmd,
   output pps_status_type     status,
   input  logic [ARR_W-1:0]   arrival_time,
   input  logic [BURST_W-1:0] burst_time,
   input  logic [PRIO_W-1:0]  prio_level,
   input  logic               last_process,
   output logic [PIDX_W-1:0]  process_index,
   output logic [TIME_W-1:0]  finish_time,
   output logic [TAT_W-1:0]   turnaround_time,
   output logic [TAT_W-1:0]   waiting_time,
   output logic               last_result
);

   // Process stores
   logic [ARR_W-1:0]   arr_ff   [MAX_PROCS];
   logic [BURST_W-1:0] burst_ff [MAX_PROCS];
   logic [PRIO_W-1:0]  prio_ff  [MAX_PROCS];
   logic [BURST_W-1:0] rem_ff   [MAX_PROCS];
   logic [TIME_W-1:0]  fin_ff   [MAX_PROCS];
   logic [MAX_PROCS-1:0] done_ff;

   // Run control
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   comp_ff, comp_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // Running choice of one scan
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [PRIO_W:0]    best_prio_ff, best_prio_in;
   logic [BURST_W-1:0] best_rem_ff, best_rem_in;
   logic               found_ff, found_in;
   logic [TIME_W-1:0]  next_arr_ff, next_arr_in;

   // Result register
   logic [PIDX_W-1:0]  out_idx_ff;
   logic [TIME_W-1:0]  out_fin_ff;
   logic [TAT_W-1:0]   out_tat_ff, out_tat_in;
   logic [TAT_W-1:0]   out_wt_ff, out_wt_in;
   logic               out_last_ff;

   logic [TIME_W-1:0]  cur_arr;
   logic               arrived;
   logic               at_last;
   logic               store_write;
   logic               finishing;
   logic [TIME_W-1:0]  tat_full;
   logic [TIME_W-1:0]  wt_full;
   logic [TIME_W-1:0]  time_inc;

   assign cur_arr     = {1'b0, arr_ff[idx_ff]};
   assign arrived     = (cur_arr <= time_ff);
   assign at_last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign store_write = cmd.load && (burst_time != '0) && (cnt_ff < CNT_W'(MAX_PROCS));
   assign finishing   = found_ff && (best_rem_ff == BURST_W'(1));
   assign time_inc    = time_ff + TIME_W'(1);

   assign status.start_run   = last_process ||
                               ((burst_time != '0) && (cnt_ff == CNT_W'(MAX_PROCS - 1)));
   assign status.empty_start = (cnt_ff == '0) && (burst_time == '0);
   assign status.scan_last   = at_last;
   assign status.run_done    = finishing && ((comp_ff + CNT_W'(1)) == cnt_ff);
   assign status.out_last    = out_last_ff;

   // Work out times for the entry under the index, saturating to the field
   assign tat_full = fin_ff[idx_ff] - {1'b0, arr_ff[idx_ff]};
   assign wt_full  = tat_full - TIME_W'(burst_ff[idx_ff]);

   always_comb begin
      out_tat_in = (|tat_full[TIME_W-1:TAT_W]) ? TAT_MAX : tat_full[TAT_W-1:0];
      out_wt_in  = (|wt_full[TIME_W-1:TAT_W]) ? TAT_MAX : wt_full[TAT_W-1:0];
   end

   // Next values of counters, clock and scan choice
   always_comb begin
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      time_in      = time_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_rem_in  = best_rem_ff;
      found_in     = found_ff;
      next_arr_in  = next_arr_ff;

      if (store_write) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      // Open a run or a fresh scan
      if (cmd.sim_start || cmd.apply) begin
         idx_in       = '0;
         best_idx_in  = '0;
         best_prio_in = {1'b1, {PRIO_W{1'b0}}};
         best_rem_in  = '0;
         found_in     = 1'b0;
         next_arr_in  = '1;
      end
      if (cmd.sim_start) begin
         time_in = '0;
         comp_in = '0;
      end

      // Visit one entry per cycle
      if (cmd.scan) begin
         idx_in = idx_ff + IDX_W'(1);
         if (!done_ff[idx_ff]) begin
            if (arrived) begin
               if ({1'b0, prio_ff[idx_ff]} < best_prio_ff) begin
                  best_idx_in  = idx_ff;
                  best_prio_in = {1'b0, prio_ff[idx_ff]};
                  best_rem_in  = rem_ff[idx_ff];
                  found_in     = 1'b1;
               end
            end else if (cur_arr < next_arr_ff) begin
               next_arr_in = cur_arr;
            end
         end
      end

      // Run the chosen process for one tick, or skip to the next arrival
      if (cmd.apply) begin
         if (found_ff) begin
            time_in = time_inc;
            if (finishing) begin
               comp_in = comp_ff + CNT_W'(1);
            end
         end else begin
            time_in = next_arr_ff;
         end
      end

      if (cmd.fill) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.finish) begin
         cnt_in  = '0;
         comp_in = '0;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         comp_ff  <= '0;
         time_ff  <= '0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         time_ff  <= time_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_rem_ff  <= best_rem_in;
      next_arr_ff  <= next_arr_in;
   end

   // Store writes: record load, tick service and completion
   always_ff @(posedge clock) begin
      if (store_write) begin
         arr_ff[cnt_ff[IDX_W-1:0]]   <= arrival_time;
         burst_ff[cnt_ff[IDX_W-1:0]] <= burst_time;
         prio_ff[cnt_ff[IDX_W-1:0]]  <= prio_level;
         rem_ff[cnt_ff[IDX_W-1:0]]   <= burst_time;
      end
      if (cmd.apply && found_ff) begin
         rem_ff[best_idx_ff] <= best_rem_ff - BURST_W'(1);
         if (finishing) begin
            fin_ff[best_idx_ff] <= time_inc;
         end
      end
   end

   // Completion flags, cleared by reset and at the end of each report
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         done_ff <= '0;
      end else if (cmd.apply && finishing) begin
         done_ff[best_idx_ff] <= 1'b1;
      end
   end

   // Capture one result
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         out_idx_ff  <= PIDX_W'(idx_ff);
         out_fin_ff  <= fin_ff[idx_ff];
         out_tat_ff  <= out_tat_in;
         out_wt_ff   <= out_wt_in;
         out_last_ff <= at_last;
      end
   end

   assign process_index   = out_idx_ff;
   assign finish_time     = out_fin_ff;
   assign turnaround_time = out_tat_ff;
   assign waiting_time    = out_wt_ff;
   assign last_result     = out_last_ff;

endmodule

[hw/rtl/preemptive_priority_scheduler.sv]
// Channel    Direction  Carries
// req_chan   in         process record: arrival, burst, priority, last flag
// rsp_chan   out        per-process result: index, finish, turnaround, waiting
//
// Loading accepts one request per cycle; requests are taken only while loading.
// Each tick of a run scans the n stored processes one entry at a time, then
// applies the tick; ticks are the total burst plus one per idle gap. Each
// result is then captured in the fill state and held until it is taken.
// Reset is synchronous and active high; it empties the store.
module preemptive_priority_scheduler import pps_pkg::*; (
   input logic      clock,
   input logic      reset,
   pps_req_if.sink  req_chan,
   pps_rsp_if.source rsp_chan
);

   pps_cmd_type    cmd;
   pps_status_type status;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pps_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .arrival_time    (req_chan.arrival_time),
      .burst_time      (req_chan.burst_time),
      .prio_level      (req_chan.prio_level),
      .last_process    (req_chan.last_process),
      .process_index   (rsp_chan.process_index),
      .finish_time     (rsp_chan.finish_time),
      .turnaround_time (rsp_chan.turnaround_time),
      .waiting_time    (rsp_chan.waiting_time),
      .last_result     (rsp_chan.last_result)
   );

endmodule

[hw/rtl/pps_checker.sv]
`include "preemptive_priority_scheduler_macros.svh"

module pps_checker import pps_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [PIDX_W-1:0] process_index,
   input logic [TIME_W-1:0] finish_time,
   input logic [TAT_W-1:0]  turnaround_time,
   input logic [TAT_W-1:0]  waiting_time,
   input logic              last_result
);

   logic                            rsp_stall;
   logic [PIDX_W+TIME_W+2*TAT_W:0]  rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {process_index, finish_time, turnaround_time, waiting_time, last_result};

   // Hold a stalled result
   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // No request is taken while results are draining
   `PPS_ASSERT_NOW(a_no_req_in_report, clock, reset, rsp_valid, !req_ready)

   // Waiting never exceeds turnaround
   `PPS_ASSERT_NOW(a_wait_le_tat, clock, reset, rsp_valid, waiting_time <= turnaround_time)

   // Turnaround never exceeds finish time
   `PPS_ASSERT_NOW(a_tat_le_fin, clock, reset, rsp_valid, {5'd0, turnaround_time} <= finish_time)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .process_index   (rsp_chan.process_index),
   .finish_time     (rsp_chan.finish_time),
   .turnaround_time (rsp_chan.turnaround_time),
   .waiting_time    (rsp_chan.waiting_time),
   .last_result     (rsp_chan.last_result)
);

[test/tb_preemptive_priority_scheduler.sv]
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler;
   import pps_pkg::*;

   localparam int unsigned TARGET_PROCS   = 470;
   localparam int unsigned WATCHDOG_LIMIT = 300000;
   localparam int unsigned TAIL_CYCLES    = 60;
   localparam int unsigned LONG_HOLD      = 500;
   localparam int unsigned HOLD_AFTER     = 60;
   localparam int unsigned FINISH_CEIL    = (1 << TIME_W) - 1;
   localparam int unsigned TAT_CEIL       = (1 << TAT_W) - 1;
   localparam int unsigned ARR_TOP        = (1 << ARR_W) - 1;
   localparam int unsigned PRIO_TOP       = (1 << PRIO_W) - 1;
   localparam int unsigned BURST_TOP      = (1 << BURST_W) - 1;

   // One process record as offered on the request channel
   typedef struct {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               last;
      bit                 settle;   // hold back until every report has come
   } proc_request_type;

   // One expected per-process report
   typedef struct {
      logic [PIDX_W-1:0] proc_idx;
      logic [TIME_W-1:0] finish;
      logic [TAT_W-1:0]  turnaround;
      logic [TAT_W-1:0]  waiting;
      logic              last;
   } proc_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pps_req_if req_chan ();
   pps_rsp_if rsp_chan ();

   preemptive_priority_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   proc_request_type record_q[$];
   proc_report_type  report_q[$];

   // Predictor copy of the process store
   logic [ARR_W-1:0]   rec_arrival[MAX_PROCS];
   logic [BURST_W-1:0] rec_burst[MAX_PROCS];
   logic [PRIO_W-1:0]  rec_prio[MAX_PROCS];
   int unsigned        rec_count = 0;

   int unsigned planned_procs = 0;
   int unsigned fail_count    = 0;
   int unsigned req_taken     = 0;
   int unsigned req_seen      = 0;
   int unsigned rsp_count     = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned gap_left      = 0;
   int unsigned hold_left     = 0;
   bit          req_calm      = 1'b0;
   bit          rsp_calm      = 1'b0;
   bit          long_hold_done = 1'b0;

   always #6 clock = ~clock;

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 9);
      if (r < 5)
         return 0;
      if (r < 9)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_record(int unsigned arr, int unsigned burst,
                                       int unsigned prio, bit last, bit settle);
      proc_request_type rec;
      rec.arrival = ARR_W'(arr);
      rec.burst   = BURST_W'(burst);
      rec.prio    = PRIO_W'(prio);
      rec.last    = last;
      rec.settle  = settle;
      record_q.insert(record_q.size(), rec);
      if (burst != 0)
         planned_procs++;
   endfunction

   function automatic int unsigned pick_prio();
      return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, PRIO_TOP);
   endfunction

   // Plan one set of n stored records with clustered arrivals
   function automatic void plan_batch(int unsigned n);
      int unsigned base;
      int unsigned spread;
      int unsigned burst_hi;
      int unsigned arr;
      bit          settle;
      bit          last;
      base     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ARR_TOP) : $urandom_range(0, 40);
      spread   = ($urandom_range(0, 3) == 0) ? 400 : 30;
      burst_hi = ($urandom_range(0, 4) == 0) ? 40 : 12;
      if (n <= 4 && $urandom_range(0, 9) == 0)
         burst_hi = BURST_TOP;
      settle   = ($urandom_range(0, 14) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            arr = $urandom_range(0, ARR_TOP);
         else
            arr = base + $urandom_range(0, spread);
         if (arr > ARR_TOP)
            arr = ARR_TOP;
         // drop in a zero-burst record now and then; it must not be stored
         if (i != 0 && i + 1 < n && $urandom_range(0, 19) == 0)
            push_record(arr, 0, pick_prio(), 1'b0, 1'b0);
         last = (i + 1 == n);
         if (n == MAX_PROCS && last)
            last = 1'($urandom_range(0, 1));
         push_record(arr, $urandom_range(1, burst_hi), pick_prio(), last, settle && i == 0);
      end
   endfunction

   // Run the preemptive schedule over the stored set and queue its reports
   function automatic void simulate_schedule();
      int unsigned     left[MAX_PROCS];
      int unsigned     finish_at[MAX_PROCS];
      bit              done[MAX_PROCS];
      int unsigned     now;
      int unsigned     completed;
      int unsigned     best;
      int unsigned     best_prio;
      int unsigned     next_arr;
      int unsigned     tat;
      int unsigned     wt;
      bit              found;
      proc_report_type rep;
      now       = 0;
      completed = 0;
      for (int i = 0; i < rec_count; i++) begin
         left[i] = rec_burst[i];
         done[i] = 1'b0;
      end
      while (completed < rec_count) begin
         found     = 1'b0;
         best      = 0;
         best_prio = PRIO_TOP + 1;
         next_arr  = 32'hFFFF_FFFF;
         for (int i = 0; i < rec_count; i++) begin
            if (!done[i]) begin
               if (rec_arrival[i] <= now) begin
                  if (rec_prio[i] < best_prio) begin
                     best_prio = rec_prio[i];
                     best      = i;
                     found     = 1'b1;
                  end
               end else if (rec_arrival[i] < next_arr) begin
                  next_arr = rec_arrival[i];
               end
            end
         end
         if (!found) begin
            // idle: jump to the next arrival
            now = next_arr;
         end else begin
            left[best]--;
            now++;
            if (left[best] == 0) begin
               finish_at[best] = now;
               done[best]      = 1'b1;
               completed++;
            end
         end
      end
      for (int i = 0; i < rec_count; i++) begin
         tat = finish_at[i] - rec_arrival[i];
         wt  = tat - rec_burst[i];
         rep.proc_idx   = PIDX_W'(i);
         rep.finish     = TIME_W'((finish_at[i] > FINISH_CEIL) ? FINISH_CEIL : finish_at[i]);
         rep.turnaround = TAT_W'((tat > TAT_CEIL) ? TAT_CEIL : tat);
         rep.waiting    = TAT_W'((wt > TAT_CEIL) ? TAT_CEIL : wt);
         rep.last       = (i + 1 == rec_count);
         report_q.insert(report_q.size(), rep);
      end
      rec_count = 0;
   endfunction

   // Store one accepted record; start the schedule on last or full store
   function automatic void load_process(proc_request_type rec);
      if (rec.burst != 0 && rec_count < MAX_PROCS) begin
         rec_arrival[rec_count] = rec.arrival;
         rec_burst[rec_count]   = rec.burst;
         rec_prio[rec_count]    = rec.prio;
         rec_count++;
      end
      if (rec.last || rec_count >= MAX_PROCS)
         simulate_schedule();
   endfunction

   function automatic void check_field(string what, int unsigned idx,
                                       logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch on process %0d, expected %0d, actual %0d",
                  $time, what, idx, want, got);
         fail_count++;
      end
   endfunction

   // Request driver: present the next record once the previous one is taken
   always @(negedge clock) begin
      proc_request_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!(req_chan.valid && req_taken == req_seen)) begin
         if (req_chan.valid) begin
            req_seen = req_taken;
            gap_left = pick_gap(req_calm);
         end
         if (gap_left != 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (record_q.size() != 0 && (!record_q[0].settle || report_q.size() == 0)) begin
            nxt = record_q.pop_front();
            req_chan.arrival_time <= nxt.arrival;
            req_chan.burst_time   <= nxt.burst;
            req_chan.prio_level   <= nxt.prio;
            req_chan.last_process <= nxt.last;
            req_chan.valid        <= 1'b1;
            if ($urandom_range(0, 29) == 0)
               req_calm = !req_calm;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Report receiver: random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 149) == 0)
            rsp_calm = !rsp_calm;
         if (hold_left == 0) begin
            if (!long_hold_done && rsp_count >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               hold_left      = LONG_HOLD;
            end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
               hold_left = pick_gap(1'b0);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each request, check each report, watch for a hang
   always @(posedge clock) begin
      proc_request_type rec;
      proc_report_type  want;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            rsp_count++;
            if (report_q.size() == 0) begin
               $display("%0t: unexpected report, actual process %0d finish %0d",
                        $time, rsp_chan.process_index, rsp_chan.finish_time);
               fail_count++;
            end else begin
               want = report_q.pop_front();
               check_field("process_index", want.proc_idx, want.proc_idx,
                           rsp_chan.process_index);
               check_field("finish_time", want.proc_idx, want.finish, rsp_chan.finish_time);
               check_field("turnaround_time", want.proc_idx, want.turnaround,
                           rsp_chan.turnaround_time);
               check_field("waiting_time", want.proc_idx, want.waiting, rsp_chan.waiting_time);
               check_field("last_result", want.proc_idx, want.last, rsp_chan.last_result);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            req_taken++;
            rec.arrival = req_chan.arrival_time;
            rec.burst   = req_chan.burst_time;
            rec.prio    = req_chan.prio_level;
            rec.last    = req_chan.last_process;
            rec.settle  = 1'b0;
            load_process(rec);
         end
         if (moved)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned pick;
      req_chan.valid        = 1'b0;
      req_chan.arrival_time = '0;
      req_chan.burst_time   = '0;
      req_chan.prio_level   = '0;
      req_chan.last_process = 1'b0;
      rsp_chan.ready        = 1'b0;

      // single shortest process
      push_record(0, 1, 0, 1'b1, 1'b0);
      // start with an empty store
      push_record(100, 0, 7, 1'b1, 1'b0);
      // zero bursts around a stored record; the last one starts the run
      push_record(5, 0, 3, 1'b0, 1'b0);
      push_record(0, 3, 2, 1'b0, 1'b0);
      push_record(1, 0, 9, 1'b1, 1'b0);
      // preemption, priority tie and an idle gap, after a full drain
      push_record(0, 5, 5, 1'b0, 1'b1);
      push_record(2, 2, 1, 1'b0, 1'b0);
      push_record(2, 1, 1, 1'b0, 1'b0);
      push_record(20, 3, 0, 1'b1, 1'b0);
      // full store of longest bursts; the filling record is not marked last
      for (int i = 0; i < MAX_PROCS; i++) begin
         push_record((i == 0) ? 0 : (i == 1) ? ARR_TOP : $urandom_range(0, 3000),
                     BURST_TOP,
                     (i == 0) ? PRIO_TOP : (i == 2) ? 0 : $urandom_range(0, PRIO_TOP),
                     1'b0, 1'b0);
      end

      // random sets, with a pause for a full drain in the first one
      plan_batch($urandom_range(2, 5));
      record_q[record_q.size() - 1].settle = 1'b1;
      while (planned_procs < TARGET_PROCS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            push_record($urandom_range(0, ARR_TOP), 0, pick_prio(),
                        1'($urandom_range(0, 1)), 1'b0);
         else if (pick < 14)
            plan_batch(MAX_PROCS);
         else if (pick < 30)
            plan_batch($urandom_range(6, 12));
         else
            plan_batch($urandom_range(1, 5));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: every record taken and every report seen
      while (record_q.size() != 0 || req_chan.valid || report_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
